// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- design/occ_pkg.sv -----
// Shared types and constants of the directional occupancy counter.
// No dependencies; used by every module of the block by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package occ_pkg;

	localparam int COUNT_MAX = 255;
	localparam int COUNT_W = 8;
	localparam int COUNT_CEIL_I = (COUNT_MAX > 255) ? 255 : COUNT_MAX;
	localparam logic [COUNT_W-1:0] COUNT_CEIL = COUNT_W'(COUNT_CEIL_I);

	localparam int TIME_W = 32;
	localparam int SPAN_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [SPAN_W-1:0] LOCKOUT_RST = 16'd1000;
	localparam logic [SPAN_W-1:0] ABORT_RST = 16'd10000;
	localparam logic [SPAN_W-1:0] LIGHT_HOLD_RST = 16'd5000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOCKOUT = 2'd0,
		CFG_ABORT = 2'd1,
		CFG_LIGHT_HOLD = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MOT_WAIT = 2'd0,
		MOT_ENTER = 2'd1,
		MOT_LEAVE = 2'd2
	} motion_t;

	typedef enum logic [1:0] {
		EVT_NONE = 2'd0,
		EVT_ADD = 2'd1,
		EVT_REMOVE = 2'd2
	} event_t;

	typedef struct packed {
		logic [TIME_W-1:0] now_ms;
		logic entry_near;
		logic exit_near;
		logic seat_near;
	} occ_in_t;

	typedef struct packed {
		logic [COUNT_W-1:0] people;
		logic occupied;
		logic [1:0] motion;
		logic saw_entry;
		logic saw_exit;
		logic seat_light;
		logic [1:0] event_res;
	} occ_out_t;

	typedef struct packed {
		logic [SPAN_W-1:0] lockout_ms;
		logic [SPAN_W-1:0] abort_ms;
		logic [SPAN_W-1:0] light_hold_ms;
	} occ_cfg_t;

	typedef struct packed {
		motion_t motion;
		logic entry_seen;
		logic exit_seen;
		logic [COUNT_W-1:0] head_count;
		logic in_use;
		logic [TIME_W-1:0] lockout_start;
		logic [TIME_W-1:0] abort_start;
		logic [TIME_W-1:0] light_start;
		logic light_on;
	} occ_state_t;

endpackage

`default_nettype wire

// ----- design/directional_occupancy_counter.sv -----
// Top level of the directional occupancy counter: handshakes, pipeline and state.
// Depends on occ_pkg, occ_cfg_regs and occ_update.
//
//   Channel   Signals                                 Direction  Transfer
//   sample    sample_valid, sample_ready, sample       in         valid & ready
//   result    result_valid, result_ready, result      out        valid & ready
//   config    cfg_we, cfg_index, cfg_data             in         cfg_we high
//
// One item is taken per cycle while the input stage is empty or moving on; its result is then
// offered on the result port. The input stage registers the item, and the update is evaluated
// from it by the combinational logic between the two registers, into the result register.
// A stalled result holds in the result register while one more item waits in the input stage.
// Reset is asynchronous and active low; it clears the state and both valid flags at once.
`timescale 1ns / 1ps
`default_nettype none

module directional_occupancy_counter (
	input wire clk,
	input wire arst_n,
	input wire sample_valid,
	output logic sample_ready,
	input wire occ_pkg::occ_in_t sample,
	output logic result_valid,
	input wire result_ready,
	output occ_pkg::occ_out_t result,
	input wire cfg_we,
	input wire [occ_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire [occ_pkg::SPAN_W-1:0] cfg_data
);

	occ_pkg::occ_cfg_t cfg;
	occ_pkg::occ_state_t st_q;
	occ_pkg::occ_state_t st_nxt;
	occ_pkg::occ_out_t res_nxt;

	occ_pkg::occ_in_t sample_s1;
	logic vld_s1;
	occ_pkg::occ_out_t result_s2;
	logic vld_s2;
	logic advance;

	occ_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	occ_update u_upd (
		.smp(sample_s1),
		.cur(st_q),
		.cfg(cfg),
		.nxt(st_nxt),
		.res(res_nxt)
	);

	// The item in the input stage moves on when the result register is free
	// or is being emptied in this cycle. The state is committed at that moment.
	assign advance = vld_s1 && (!vld_s2 || result_ready);
	assign sample_ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (sample_valid && sample_ready) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			sample_s1 <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (result_ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= res_nxt;
		end
	end

	// Sequence state, count, timer starts and light level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.motion <= occ_pkg::MOT_WAIT;
			st_q.entry_seen <= 1'b0;
			st_q.exit_seen <= 1'b0;
			st_q.head_count <= '0;
			st_q.in_use <= 1'b0;
			st_q.lockout_start <= '0;
			st_q.abort_start <= '0;
			st_q.light_start <= '0;
			st_q.light_on <= 1'b0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	assign result_valid = vld_s2;
	assign result = result_s2;

endmodule

`default_nettype wire

// ----- design/occ_cfg_regs.sv -----
// Configuration registers: lockout, abort and light hold spans.
// Depends on occ_pkg.
`timescale 1ns / 1ps
`default_nettype none

module occ_cfg_regs (
	input wire clk,
	input wire arst_n,
	input wire cfg_we,
	input wire [occ_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire [occ_pkg::SPAN_W-1:0] cfg_data,
	output occ_pkg::occ_cfg_t cfg
);

	occ_pkg::occ_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lockout_ms <= occ_pkg::LOCKOUT_RST;
			cfg_q.abort_ms <= occ_pkg::ABORT_RST;
			cfg_q.light_hold_ms <= occ_pkg::LIGHT_HOLD_RST;
		end else if (cfg_we) begin
			// An index beyond the register list is ignored.
			unique case (cfg_index)
				occ_pkg::CFG_LOCKOUT: begin
					cfg_q.lockout_ms <= cfg_data;
				end
				occ_pkg::CFG_ABORT: begin
					cfg_q.abort_ms <= cfg_data;
				end
				occ_pkg::CFG_LIGHT_HOLD: begin
					cfg_q.light_hold_ms <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- design/occ_update.sv -----
// Per-pass update: abort timeout, entry, exit and seat handling, result build.
// Depends on occ_pkg; purely combinational.
`timescale 1ns / 1ps
`default_nettype none

module occ_update (
	input wire occ_pkg::occ_in_t smp,
	input wire occ_pkg::occ_state_t cur,
	input wire occ_pkg::occ_cfg_t cfg,
	output occ_pkg::occ_state_t nxt,
	output occ_pkg::occ_out_t res
);

	occ_pkg::event_t evt;

	// A timer has run out when the wrapped elapsed time exceeds its span.
	function automatic logic expired(
		input logic [occ_pkg::TIME_W-1:0] now,
		input logic [occ_pkg::TIME_W-1:0] start,
		input logic [occ_pkg::SPAN_W-1:0] span
	);
		logic [occ_pkg::TIME_W-1:0] elapsed;
		elapsed = now - start;
		return elapsed > {{(occ_pkg::TIME_W - occ_pkg::SPAN_W){1'b0}}, span};
	endfunction

	// Next state, evaluated in the same order as the sensors are polled.
	always_comb begin
		nxt = cur;
		evt = occ_pkg::EVT_NONE;

		if ((nxt.motion == occ_pkg::MOT_ENTER || nxt.motion == occ_pkg::MOT_LEAVE) &&
			expired(smp.now_ms, cur.abort_start, cfg.abort_ms)) begin
			nxt.motion = occ_pkg::MOT_WAIT;
			nxt.entry_seen = 1'b0;
			nxt.exit_seen = 1'b0;
		end

		// Entry sensor.
		if (nxt.motion == occ_pkg::MOT_WAIT && smp.entry_near &&
			expired(smp.now_ms, nxt.lockout_start, cfg.lockout_ms)) begin
			nxt.motion = occ_pkg::MOT_ENTER;
			nxt.entry_seen = 1'b1;
			nxt.abort_start = smp.now_ms;
		end
		if (nxt.motion == occ_pkg::MOT_LEAVE) begin
			if (nxt.exit_seen && smp.entry_near) begin
				nxt.entry_seen = 1'b1;
			end
			if (nxt.exit_seen && nxt.entry_seen && !smp.entry_near) begin
				nxt.motion = occ_pkg::MOT_WAIT;
				nxt.entry_seen = 1'b0;
				nxt.exit_seen = 1'b0;
				if (nxt.head_count != '0) begin
					nxt.head_count = nxt.head_count - occ_pkg::COUNT_W'(1);
				end
				if (nxt.head_count == '0) begin
					nxt.in_use = 1'b0;
				end
				nxt.lockout_start = smp.now_ms;
				evt = occ_pkg::EVT_REMOVE;
			end
		end

		// Exit sensor; sees the lockout start that the entry step may have moved.
		if (nxt.motion == occ_pkg::MOT_WAIT && smp.exit_near &&
			expired(smp.now_ms, nxt.lockout_start, cfg.lockout_ms)) begin
			nxt.motion = occ_pkg::MOT_LEAVE;
			nxt.exit_seen = 1'b1;
			nxt.abort_start = smp.now_ms;
		end
		if (nxt.motion == occ_pkg::MOT_ENTER) begin
			if (nxt.entry_seen && smp.exit_near) begin
				nxt.exit_seen = 1'b1;
			end
			if (nxt.entry_seen && nxt.exit_seen && !smp.exit_near) begin
				nxt.motion = occ_pkg::MOT_WAIT;
				nxt.entry_seen = 1'b0;
				nxt.exit_seen = 1'b0;
				if (nxt.head_count < occ_pkg::COUNT_CEIL) begin
					nxt.head_count = nxt.head_count + occ_pkg::COUNT_W'(1);
				end
				nxt.in_use = 1'b1;
				nxt.lockout_start = smp.now_ms;
				evt = occ_pkg::EVT_ADD;
			end
		end

		// Seat sensor.
		if (smp.seat_near) begin
			nxt.light_on = 1'b1;
			nxt.light_start = smp.now_ms;
		end else if (expired(smp.now_ms, cur.light_start, cfg.light_hold_ms)) begin
			nxt.light_on = 1'b0;
		end
	end

	// Result fields show the state after the update.
	always_comb begin
		res.people = nxt.head_count;
		res.occupied = nxt.in_use;
		res.motion = nxt.motion;
		res.saw_entry = nxt.entry_seen;
		res.saw_exit = nxt.exit_seen;
		res.seat_light = nxt.light_on;
		res.event_res = evt;
	end

endmodule

`default_nettype wire

// ----- design/occ_checker.sv -----
// Port-level checker for the directional occupancy counter, bound to the top level.
// Depends on occ_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module occ_checker (
	input wire clk,
	input wire arst_n,
	input wire result_valid,
	input wire result_ready,
	input wire occ_pkg::occ_out_t result
);

	// A stalled result keeps its valid and its payload.
	`ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result))

	// The occupied flag follows a nonzero count.
	`ASSERT_IMPL(a_occupied_count, clk, arst_n, result_valid, result.occupied == (result.people != '0))

	// While waiting no sensor is marked as seen.
	`ASSERT_IMPL(a_wait_clear, clk, arst_n, result_valid && result.motion == occ_pkg::MOT_WAIT, !result.saw_entry && !result.saw_exit)

	// A counted passage always leaves the sequence back in waiting.
	`ASSERT_IMPL(a_event_wait, clk, arst_n, result_valid && result.event_res != occ_pkg::EVT_NONE, result.motion == occ_pkg::MOT_WAIT)

endmodule

bind directional_occupancy_counter occ_checker u_occ_checker (.*);

`default_nettype wire

// ----- tb/directional_occupancy_counter_tb.sv -----
// Self-checking testbench for the directional occupancy counter: directed passes, then random
// passage sequences under several timer settings, checked against an in-bench predictor.
// Depends on occ_pkg and the directional_occupancy_counter RTL.
`timescale 1ns / 1ps

module directional_occupancy_counter_tb;
	import occ_pkg::*;

	// The register list has three entries, so index 3 addresses nothing and must be ignored.
	localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	occ_in_t sample = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	occ_out_t result;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SPAN_W-1:0] cfg_data = '0;

	directional_occupancy_counter dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Polling passes waiting to be sent, and the occupancy results they must produce, in order.
	occ_in_t sample_queue[$];
	occ_out_t expected_results[$];
	occ_out_t want_res;

	// Percentage of cycles in which the sender holds back and the receiver stalls.
	int unsigned idle_pct = 27;
	int unsigned error_count = 0;
	int unsigned results_checked = 0;
	int unsigned queued_total = 0;
	int unsigned phase_count = 0;
	int unsigned entries_counted = 0;
	int unsigned exits_counted = 0;
	int unsigned adds_at_full = 0;
	int unsigned removes_at_zero = 0;
	int unsigned peak_people = 0;
	logic [TIME_W-1:0] gen_now = '0;

	// Shadow copy of the timer registers, at their reset values.
	logic [SPAN_W-1:0] cfg_lockout = LOCKOUT_RST;
	logic [SPAN_W-1:0] cfg_abort = ABORT_RST;
	logic [SPAN_W-1:0] cfg_light_hold = LIGHT_HOLD_RST;

	// Shadow copy of the counter state, at its reset values.
	motion_t st_motion = MOT_WAIT;
	logic st_entry_seen = 1'b0;
	logic st_exit_seen = 1'b0;
	logic [COUNT_W-1:0] st_people = '0;
	logic st_in_use = 1'b0;
	logic [TIME_W-1:0] st_lock_start = '0;
	logic [TIME_W-1:0] st_abort_start = '0;
	logic [TIME_W-1:0] st_light_start = '0;
	logic st_light_on = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	// A timer has run out once the wrapped distance from its start strictly exceeds the span.
	function automatic logic run_out(input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] start,
			input logic [SPAN_W-1:0] span);
		logic [TIME_W-1:0] gap;
		gap = now - start;
		return gap > {{(TIME_W - SPAN_W){1'b0}}, span};
	endfunction

	function automatic void drop_sequence();
		st_motion = MOT_WAIT;
		st_entry_seen = 1'b0;
		st_exit_seen = 1'b0;
	endfunction

	// Advances the shadow state by one polling pass and returns what the block must report.
	function automatic occ_out_t predict_pass(input occ_in_t s);
		occ_out_t r;
		event_t ev;
		ev = EVT_NONE;

		// An open passage whose abort time has run out falls back to waiting first.
		if ((st_motion == MOT_ENTER || st_motion == MOT_LEAVE) &&
				run_out(s.now_ms, st_abort_start, cfg_abort))
			drop_sequence();

		// Entry sensor: it opens an entering passage, or closes a leaving one once it clears.
		if (st_motion == MOT_WAIT && run_out(s.now_ms, st_lock_start, cfg_lockout) &&
				s.entry_near) begin
			st_motion = MOT_ENTER;
			st_entry_seen = 1'b1;
			st_abort_start = s.now_ms;
		end
		if (st_motion == MOT_LEAVE) begin
			if (st_exit_seen && s.entry_near)
				st_entry_seen = 1'b1;
			if (st_exit_seen && st_entry_seen && !s.entry_near) begin
				drop_sequence();
				if (st_people == 0)
					removes_at_zero++;
				else
					st_people--;
				if (st_people == 0)
					st_in_use = 1'b0;
				st_lock_start = s.now_ms;
				ev = EVT_REMOVE;
				exits_counted++;
			end
		end

		// Exit sensor: the mirror image, with the count held at its ceiling.
		if (st_motion == MOT_WAIT && run_out(s.now_ms, st_lock_start, cfg_lockout) &&
				s.exit_near) begin
			st_motion = MOT_LEAVE;
			st_exit_seen = 1'b1;
			st_abort_start = s.now_ms;
		end
		if (st_motion == MOT_ENTER) begin
			if (st_entry_seen && s.exit_near)
				st_exit_seen = 1'b1;
			if (st_entry_seen && st_exit_seen && !s.exit_near) begin
				drop_sequence();
				if (st_people < COUNT_CEIL)
					st_people++;
				else
					adds_at_full++;
				st_in_use = 1'b1;
				st_lock_start = s.now_ms;
				ev = EVT_ADD;
				entries_counted++;
			end
		end

		// Seat light: every detection restarts the hold time.
		if (s.seat_near) begin
			st_light_on = 1'b1;
			st_light_start = s.now_ms;
		end else if (run_out(s.now_ms, st_light_start, cfg_light_hold)) begin
			st_light_on = 1'b0;
		end

		if (st_people > peak_people)
			peak_people = st_people;

		r.people = st_people;
		r.occupied = st_in_use;
		r.motion = st_motion;
		r.saw_entry = st_entry_seen;
		r.saw_exit = st_exit_seen;
		r.seat_light = st_light_on;
		r.event_res = ev;
		return r;
	endfunction

	// Sender: an item is taken off the queue only when the channel is free, and it is held
	// until accepted. Its expected result is computed at the edge where it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else begin
			if (sample_valid && sample_ready)
				expected_results.push_back(predict_pass(sample));
			if (!sample_valid || sample_ready) begin
				if (sample_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
					sample_valid <= 1'b1;
					sample <= sample_queue.pop_front();
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string fname, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
			error_count++;
		end
	endtask

	// Receiver: each accepted result is compared field by field with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, result);
					error_count++;
				end else begin
					want_res = expected_results.pop_front();
					check_field("people", want_res.people, result.people);
					check_field("occupied", want_res.occupied, result.occupied);
					check_field("motion", want_res.motion, result.motion);
					check_field("saw_entry", want_res.saw_entry, result.saw_entry);
					check_field("saw_exit", want_res.saw_exit, result.saw_exit);
					check_field("seat_light", want_res.seat_light, result.seat_light);
					check_field("event_res", want_res.event_res, result.event_res);
					results_checked++;
				end
			end
			result_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	task automatic add_sample(input logic [TIME_W-1:0] now, input logic ent, input logic ext,
			input logic seat);
		occ_in_t s;
		s.now_ms = now;
		s.entry_near = ent;
		s.exit_near = ext;
		s.seat_near = seat;
		sample_queue.push_back(s);
		queued_total++;
	endtask

	// Walks a person past the sensors: near sensor, both, far sensor, clear. Each step may
	// repeat; a step count below four leaves the passage unfinished.
	task automatic add_passage(input logic leaving, input int unsigned nsteps,
			input int unsigned step);
		logic near_bit;
		logic far_bit;
		for (int k = 0; k < nsteps; k++) begin
			near_bit = (k < 2);
			far_bit = (k == 1 || k == 2);
			repeat ($urandom_range(1, 2)) begin
				gen_now += $urandom_range(step);
				if (leaving)
					add_sample(gen_now, far_bit, near_bit, $urandom_range(3) == 0);
				else
					add_sample(gen_now, near_bit, far_bit, $urandom_range(3) == 0);
			end
		end
	endtask

	// Mostly complete passages in both directions, with some broken ones and sensor noise.
	// Noise occasionally jumps the clock to an arbitrary value.
	task automatic run_random(input int unsigned n, input int unsigned step,
			input int unsigned gap);
		int unsigned stop_at;
		int unsigned pick;
		stop_at = queued_total + n;
		while (queued_total < stop_at) begin
			gen_now += $urandom_range(gap);
			pick = $urandom_range(99);
			if (pick < 60) begin
				add_passage(1'($urandom_range(1)), 4, step);
			end else if (pick < 75) begin
				add_passage(1'($urandom_range(1)), $urandom_range(1, 3), step);
			end else begin
				repeat ($urandom_range(1, 3)) begin
					if ($urandom_range(7) == 0)
						gen_now = $urandom;
					else
						gen_now += $urandom_range(step);
					add_sample(gen_now, 1'($urandom_range(1)), 1'($urandom_range(1)),
						1'($urandom_range(1)));
				end
			end
		end
	endtask

	// Shortest possible entries: both sensors in one pass, then clear. With no lockout this
	// drives the count up to its ceiling.
	task automatic fill_room(input int unsigned n);
		repeat (n) begin
			gen_now += $urandom_range(1, 3);
			add_sample(gen_now, 1'b1, 1'b1, 1'($urandom_range(1)));
			gen_now += $urandom_range(3);
			add_sample(gen_now, 1'b0, 1'b0, 1'($urandom_range(1)));
		end
	endtask

	// Waits until every queued item has gone through and every result is back.
	task automatic drain();
		while (sample_queue.size() != 0 || sample_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		phase_count++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SPAN_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_LOCKOUT: cfg_lockout = val;
			CFG_ABORT: cfg_abort = val;
			CFG_LIGHT_HOLD: cfg_light_hold = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_timers(input logic [SPAN_W-1:0] lock, input logic [SPAN_W-1:0] abrt,
			input logic [SPAN_W-1:0] hold);
		write_reg(CFG_LOCKOUT, lock);
		write_reg(CFG_ABORT, abrt);
		write_reg(CFG_LIGHT_HOLD, hold);
	endtask

	initial begin
		int unsigned lock;
		int unsigned abrt;
		int unsigned hold;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed passes at the reset timer values (lockout 1000, abort 10000, hold 5000).
		// The lockout from reset blocks a start at exactly its span and frees it one ms later.
		add_sample(32'd0, 1'b1, 1'b0, 1'b1);
		add_sample(32'd1000, 1'b1, 1'b0, 1'b0);
		// A full entry, counted when the exit sensor clears.
		add_sample(32'd1001, 1'b1, 1'b0, 1'b0);
		add_sample(32'd1100, 1'b1, 1'b1, 1'b0);
		add_sample(32'd1200, 1'b0, 1'b1, 1'b0);
		add_sample(32'd1300, 1'b0, 1'b0, 1'b0);
		// A leave, held off by the lockout first, which brings the room back to empty.
		add_sample(32'd2300, 1'b0, 1'b1, 1'b0);
		add_sample(32'd2301, 1'b0, 1'b1, 1'b1);
		add_sample(32'd2400, 1'b1, 1'b1, 1'b0);
		add_sample(32'd2500, 1'b0, 1'b0, 1'b0);
		// A second leave with nobody inside: the count stays at zero but the event is reported.
		add_sample(32'd3501, 1'b0, 1'b1, 1'b0);
		add_sample(32'd3600, 1'b1, 1'b0, 1'b0);
		add_sample(32'd3700, 1'b0, 1'b0, 1'b0);
		// An entry left hanging: still open at exactly the abort span, dropped one ms later.
		add_sample(32'd4701, 1'b1, 1'b0, 1'b0);
		add_sample(32'd14701, 1'b0, 1'b0, 1'b0);
		add_sample(32'd14702, 1'b0, 1'b0, 1'b0);
		// Both sensors in one pass from waiting: entry wins and the exit is seen at once.
		add_sample(32'd20000, 1'b1, 1'b1, 1'b0);
		add_sample(32'd20001, 1'b0, 1'b0, 1'b0);
		// An entry and a seat detection across the wrap of the millisecond clock.
		add_sample(32'hFFFF_FFF0, 1'b1, 1'b0, 1'b1);
		add_sample(32'h0000_0010, 1'b0, 1'b1, 1'b0);
		add_sample(32'h0000_0020, 1'b0, 1'b0, 1'b0);
		add_sample(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
		gen_now = 32'hFFFF_FFFF;
		drain();

		// All timers at zero: every timer runs out as soon as the clock moves at all.
		set_timers(16'd0, 16'd0, 16'd0);
		run_random(100, 1, 2);
		drain();

		// All timers at their maximum, with long gaps between passages.
		set_timers(16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_random(100, 3000, 140000);
		drain();

		// No lockout and back-to-back entries with no idling on either side: the count reaches
		// its ceiling and sits there. A write to the unused index must change nothing.
		// After the first 140 entries, the bench waits for every result before going on.
		set_timers(16'd0, 16'd1000, 16'd10);
		write_reg(CFG_NONE, SPAN_W'($urandom));
		idle_pct = 0;
		fill_room(140);
		drain();
		fill_room(150);
		drain();
		idle_pct = 27;

		// Random moderate timer settings with a mix of full, broken and noisy passages.
		repeat (3) begin
			lock = $urandom_range(200);
			abrt = $urandom_range(2000);
			hold = $urandom_range(500);
			set_timers(SPAN_W'(lock), SPAN_W'(abrt), SPAN_W'(hold));
			run_random(130, abrt / 3 + 2, 2 * lock + abrt / 4 + 2);
			drain();
		end

		$display("Run covered %0d polling passes in %0d phases: %0d entries and %0d exits counted.",
			results_checked, phase_count, entries_counted, exits_counted);
		$display("Peak occupancy %0d; %0d entries at full count, %0d exits from an empty room.",
			peak_people, adds_at_full, removes_at_zero);
		if (error_count == 0 && expected_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog: far longer than the slowest correct run needs.
	initial begin
		#5_000_000;
		$display("Timeout with %0d results still expected.", expected_results.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
